// ===== hdl/nearest_palette_color_search_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color search unit
// Immediate-implication and next-cycle-implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define NPCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  // Fixed index width of the request and result ports
  localparam int IDX_W = 8;

  // Defaults for top-level parameters
  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_COMPONENT_BITS  = 6;

  // Components are scaled by this left shift before the distance
  localparam int SCALE_SHIFT = 2;

  // Request operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic             mem_write;    // write the request color into the palette
    logic             query_start;  // capture query color and source index
    logic             rd_en;        // read one palette entry into the scan pipe
    logic [IDX_W-1:0] rd_addr;      // palette entry to read
    logic             out_load;     // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;  // scan pipeline still holds entries
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/npcs_datapath.sv =====
// ----------------------------------------------------------------------------
// npcs_datapath
// Palette memory, distance pipeline (memory read, squared differences),
// best-match tracking and result payload register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npcs_datapath #(
  parameter int PALETTE_ENTRIES = npcs_pkg::DEF_PALETTE_ENTRIES,
  parameter int COMPONENT_BITS  = npcs_pkg::DEF_COMPONENT_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  npcs_pkg::cmd_t                cmd,
  output npcs_pkg::sts_t                sts,
  input  wire [npcs_pkg::IDX_W-1:0]     in_color_index,
  input  wire [COMPONENT_BITS-1:0]      in_red,
  input  wire [COMPONENT_BITS-1:0]      in_green,
  input  wire [COMPONENT_BITS-1:0]      in_blue,
  output logic [npcs_pkg::IDX_W-1:0]    out_source_index,
  output logic [npcs_pkg::IDX_W-1:0]    out_nearest_index
);

  localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int ENT_W  = 3 * COMPONENT_BITS;
  localparam int SC_W   = COMPONENT_BITS + npcs_pkg::SCALE_SHIFT;
  localparam int SQ_W   = 2 * SC_W;
  localparam int DST_W  = SQ_W + 2;
  localparam int CB     = COMPONENT_BITS;
  localparam logic [npcs_pkg::IDX_W:0] ENTRIES_EXT = (npcs_pkg::IDX_W + 1)'(PALETTE_ENTRIES);

  // Palette storage, reset value undefined until written
  logic [ENT_W-1:0] palette_mem [PALETTE_ENTRIES];

  // Query context
  logic [SC_W-1:0]            q_red_r, q_green_r, q_blue_r;
  logic [npcs_pkg::IDX_W-1:0] src_idx_r;

  // Pipe stage: memory read
  logic              rd_vld_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [ENT_W-1:0]  rd_data_r;

  // Pipe stage: squared differences
  logic              sq_vld_r;
  logic [ADDR_W-1:0] sq_idx_r;
  logic [SQ_W-1:0]   sq_red_r, sq_green_r, sq_blue_r;

  // Best match so far
  logic [DST_W-1:0]  best_dist_r;
  logic [ADDR_W-1:0] best_idx_r;

  // Combinational distance terms
  logic [SC_W-1:0]  e_red, e_green, e_blue;
  logic [SC_W-1:0]  d_red, d_green, d_blue;
  logic [DST_W-1:0] sum_dist;
  logic             wr_in_range;

  // Absolute difference of two scaled components
  function automatic logic [SC_W-1:0] abs_diff(input logic [SC_W-1:0] a,
                                               input logic [SC_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign wr_in_range = ({1'b0, in_color_index} < ENTRIES_EXT);

  // Write loads into the palette
  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_in_range) begin
      palette_mem[in_color_index[ADDR_W-1:0]] <= {in_red, in_green, in_blue};
    end
  end

  // Read one entry per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= palette_mem[cmd.rd_addr[ADDR_W-1:0]];
    end
  end

  // Capture query color, scaled
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_red_r   <= {in_red,   (npcs_pkg::SCALE_SHIFT)'(0)};
      q_green_r <= {in_green, (npcs_pkg::SCALE_SHIFT)'(0)};
      q_blue_r  <= {in_blue,  (npcs_pkg::SCALE_SHIFT)'(0)};
      src_idx_r <= in_color_index;
    end
  end

  // Scale stored components and take differences
  assign e_red   = {rd_data_r[3*CB-1:2*CB], (npcs_pkg::SCALE_SHIFT)'(0)};
  assign e_green = {rd_data_r[2*CB-1:CB],   (npcs_pkg::SCALE_SHIFT)'(0)};
  assign e_blue  = {rd_data_r[CB-1:0],      (npcs_pkg::SCALE_SHIFT)'(0)};
  assign d_red   = abs_diff(q_red_r,   e_red);
  assign d_green = abs_diff(q_green_r, e_green);
  assign d_blue  = abs_diff(q_blue_r,  e_blue);

  // Advance pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      sq_vld_r <= rd_vld_r;
    end
  end

  // Square the differences
  always_ff @(posedge clk) begin
    rd_idx_r   <= cmd.rd_addr[ADDR_W-1:0];
    sq_idx_r   <= rd_idx_r;
    sq_red_r   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green_r <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue_r  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

  assign sum_dist = DST_W'(sq_red_r) + DST_W'(sq_green_r) + DST_W'(sq_blue_r);

  // Keep the first strictly smaller distance; entry zero seeds the search
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_idx_r <= '0;
    end else if (sq_vld_r && ((sq_idx_r == '0) || (sum_dist < best_dist_r))) begin
      best_idx_r  <= sq_idx_r;
      best_dist_r <= sum_dist;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_source_index  <= src_idx_r;
      out_nearest_index <= npcs_pkg::IDX_W'(best_idx_r);
    end
  end

  assign sts.pipe_busy = rd_vld_r | sq_vld_r;

endmodule

`default_nettype wire

// ===== hdl/npcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcs_ctrl
// Request handshake, palette scan sequencing and result valid control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_search_unit_assert.svh"

module npcs_ctrl #(
  parameter int PALETTE_ENTRIES = npcs_pkg::DEF_PALETTE_ENTRIES
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_op,
  input  wire [npcs_pkg::IDX_W-1:0]  in_color_index,
  output logic                       out_valid,
  input  wire                        out_ready,
  output npcs_pkg::cmd_t             cmd,
  input  npcs_pkg::sts_t             sts
);

  localparam logic [npcs_pkg::IDX_W-1:0] LAST_ADDR = npcs_pkg::IDX_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t                     state_r;
  logic [npcs_pkg::IDX_W-1:0] addr_r;
  logic                       out_valid_r;
  logic                       accept;
  logic                       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Issue datapath commands
  always_comb begin
    cmd.mem_write   = accept && (in_op == npcs_pkg::OP_LOAD);
    cmd.query_start = accept && (in_op == npcs_pkg::OP_QUERY);
    cmd.rd_en       = (state_r == S_SCAN);
    cmd.rd_addr     = addr_r;
    cmd.out_load    = (state_r == S_HOLD) && slot_free;
  end

  // Hold state, scan address and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.query_start) begin
            addr_r  <= '0;
            state_r <= (in_color_index == '0) ? S_HOLD : S_SCAN;
          end
        end
        S_SCAN: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST_ADDR) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!sts.pipe_busy) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // New requests only with an empty scan pipeline
  `NPCS_ASSERT_SAME(a_ready_pipe_empty, clk, rst_n, in_ready, !sts.pipe_busy, "request taken while scan pipe busy")
  // A result is loaded only into a free output slot
  `NPCS_ASSERT_SAME(a_load_slot_free, clk, rst_n, cmd.out_load, slot_free, "result overwritten before taken")
  // Every read enters the scan pipeline
  `NPCS_ASSERT_NEXT(a_read_tracked, clk, rst_n, cmd.rd_en, sts.pipe_busy, "palette read lost from scan pipe")
  // The scan stops after the last entry
  `NPCS_ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_r == S_SCAN) && (addr_r == LAST_ADDR), state_r == S_DRAIN, "scan ran past last entry")

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_color_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// Nearest color search over a loadable target palette.
// ----------------------------------------------------------------------------
// A load request (op 0) writes one palette entry and gives no result; loads
// to an index not below PALETTE_ENTRIES are dropped. A query request (op 1)
// with a nonzero source index scans every palette entry through one distance
// unit, one entry per cycle from the single read port of the palette memory,
// and returns the lowest index of minimum squared distance. A query with
// source index 0 returns target 0 without a scan. One query is in work at a
// time; a finished result waits in the output register while the next
// request is taken.
// Palette entries must be written before a query reads them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_search_unit #(
  parameter int PALETTE_ENTRIES = npcs_pkg::DEF_PALETTE_ENTRIES,
  parameter int COMPONENT_BITS  = npcs_pkg::DEF_COMPONENT_BITS
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_op,
  input  wire [npcs_pkg::IDX_W-1:0]  in_color_index,
  input  wire [COMPONENT_BITS-1:0]   in_red,
  input  wire [COMPONENT_BITS-1:0]   in_green,
  input  wire [COMPONENT_BITS-1:0]   in_blue,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [npcs_pkg::IDX_W-1:0] out_source_index,
  output logic [npcs_pkg::IDX_W-1:0] out_nearest_index
);

  npcs_pkg::cmd_t cmd;
  npcs_pkg::sts_t sts;

  // Sequencing and handshakes
  npcs_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_color_index (in_color_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts)
  );

  // Palette memory and distance pipeline
  npcs_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COMPONENT_BITS  (COMPONENT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_color_index    (in_color_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_source_index  (out_source_index),
    .out_nearest_index (out_nearest_index)
  );

endmodule

`default_nettype wire
